// ===== design/dnsw_pkg.sv =====
// Shared types, codes and constants of the day/night IR-cut switch controller.
`timescale 1ns / 1ps

package dnsw_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int TIME_BITS_DEF = 16;

    localparam int ELAPSED_W = 12;
    localparam int LUMA_W = 8;
    localparam int HOLD_W = 16;
    localparam int SETTLE_W = 12;
    localparam int SAT_W = 8;
    localparam int WR_INDEX_W = 3;
    localparam int WR_DATA_W = 16;

    localparam int RESULT_BITS = 25;
    localparam int OUT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;

    localparam int ADC_THRESHOLD_RST = 80;
    localparam logic [LUMA_W-1:0] LUMA_DARK_LIMIT_RST = 8'd11;
    localparam logic [HOLD_W-1:0] HOLD_MS_RST = 16'd2000;
    localparam logic [SETTLE_W-1:0] SETTLE_MS_RST = 12'd350;
    localparam logic [SAT_W-1:0] SAT_DAY = 8'd128;
    localparam logic [SAT_W-1:0] SAT_NIGHT = 8'd0;

    localparam logic STATE_DAY = 1'b1;
    localparam logic STATE_NIGHT = 1'b0;

    typedef enum logic [1:0] {
        MODE_AUTO  = 2'd0,
        MODE_NIGHT = 2'd1,
        MODE_DAY   = 2'd2
    } ir_mode_t;

    typedef enum logic [WR_INDEX_W-1:0] {
        REG_IR_MODE         = 3'd0,
        REG_ADC_THRESHOLD   = 3'd1,
        REG_LUMA_DARK_LIMIT = 3'd2,
        REG_HOLD_MS         = 3'd3,
        REG_SETTLE_MS       = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        ACT_STATUS = 2'd0,
        ACT_PINS   = 2'd1,
        ACT_ISP    = 2'd2
    } action_t;

    typedef struct packed {
        action_t               action;
        logic                  color_mode;
        logic                  ir_light_on;
        logic                  ircut_level;
        logic [SAT_W-1:0]      isp_saturation;
        logic [SETTLE_W-1:0]   wait_after_ms;
        logic                  last_of_run;
    } result_t;

    function automatic result_t make_result(action_t act, logic st,
                                            logic [SETTLE_W-1:0] wait_ms, logic last);
        result_t r;
        r.action = act;
        r.color_mode = st;
        r.ir_light_on = ~st;
        r.ircut_level = ~st;
        r.isp_saturation = st ? SAT_DAY : SAT_NIGHT;
        r.wait_after_ms = wait_ms;
        r.last_of_run = last;
        return r;
    endfunction

endpackage

// ===== design/day_night_ircut_switch.sv =====
// Top level of the day/night IR-cut switch controller with stream ports.
//
// Channel    Direction  Transfer carries
// s_axis     in         one poll: elapsed_ms, avg_luma, adc_sample
// m_axis     out        one result step; tlast marks the last step of a poll
// wr_*       in         one configuration register write, no read-back
//
// A poll is taken into an input register and evaluated once the result buffer is
// empty or drains in that cycle. A poll gives one status result or two switch
// steps, sent one per cycle while m_axis_tready is high. The buffer lets a new
// poll be taken while a result still waits. Reset restores every configuration
// register to its default and the block to day colour.
`timescale 1ns / 1ps

module day_night_ircut_switch
    import dnsw_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // elapsed_ms [11:0], avg_luma [19:12], adc_sample [19+ADC_BITS:20], zero fill
    input  logic [((ELAPSED_W + LUMA_W + ADC_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // action [1:0], color_mode [2], ir_light_on [3], ircut_level [4],
    // isp_saturation [12:5], wait_after_ms [24:13], zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  wr_en,
    input  logic [WR_INDEX_W-1:0] wr_index,
    input  logic [WR_DATA_W-1:0]  wr_data
);

    localparam int LUMA_LO = ELAPSED_W;
    localparam int ADC_LO = ELAPSED_W + LUMA_W;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [LUMA_W-1:0]    luma_reg;
    logic [ADC_BITS-1:0]  adc_reg;

    result_t              buf0_reg;
    result_t              buf0_next;
    result_t              buf1_reg;
    result_t              buf1_next;
    logic [1:0]           cnt_reg;
    logic [1:0]           cnt_next;

    result_t              res0;
    result_t              res1;
    logic                 two_results;
    logic                 step;
    logic                 s_fire;
    logic                 m_fire;

    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign step = in_valid_reg && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_axis_tready));
    assign s_axis_tready = !in_valid_reg || step;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_fire || (in_valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            elapsed_reg <= s_axis_tdata[ELAPSED_W-1:0];
            luma_reg <= s_axis_tdata[LUMA_LO +: LUMA_W];
            adc_reg <= s_axis_tdata[ADC_LO +: ADC_BITS];
        end
    end

    dnsw_core #(
        .ADC_BITS  (ADC_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .step        (step),
        .elapsed_ms  (elapsed_reg),
        .avg_luma    (luma_reg),
        .adc_sample  (adc_reg),
        .res0        (res0),
        .res1        (res1),
        .two_results (two_results)
    );

    always_comb
    begin
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        cnt_next = cnt_reg;
        priority if (step)
        begin
            buf0_next = res0;
            buf1_next = res1;
            cnt_next = two_results ? 2'd2 : 2'd1;
        end
        else if (m_fire)
        begin
            buf0_next = buf1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tlast = buf0_reg.last_of_run;
    assign m_axis_tdata = {(OUT_TDATA_W - RESULT_BITS)'(0),
                           buf0_reg.wait_after_ms,
                           buf0_reg.isp_saturation,
                           buf0_reg.ircut_level,
                           buf0_reg.ir_light_on,
                           buf0_reg.color_mode,
                           buf0_reg.action};

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("Result buffer count out of range.");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !buf0_reg.last_of_run)
        else $error("First step of a switch is marked as last.");

    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_axis_tvalid)
        else $error("An evaluated poll produced no result.");

    a_stall_holds_poll: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && cnt_reg != 2'd0)
        else $error("Input stalled with nothing pending.");

endmodule

// ===== design/dnsw_core.sv =====
// Configuration registers, day/night decision state and result generation.
`timescale 1ns / 1ps

module dnsw_core
    import dnsw_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [WR_INDEX_W-1:0] wr_index,
    input  logic [WR_DATA_W-1:0]  wr_data,
    input  logic                  step,
    input  logic [ELAPSED_W-1:0]  elapsed_ms,
    input  logic [LUMA_W-1:0]     avg_luma,
    input  logic [ADC_BITS-1:0]   adc_sample,
    output result_t               res0,
    output result_t               res1,
    output logic                  two_results
);

    localparam int CMP_W = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

    logic [1:0]           ir_mode_reg;
    logic [ADC_BITS-1:0]  adc_threshold_reg;
    logic [LUMA_W-1:0]    luma_dark_limit_reg;
    logic [HOLD_W-1:0]    hold_ms_reg;
    logic [SETTLE_W-1:0]  settle_ms_reg;

    logic                 wanted_reg;
    logic                 wanted_next;
    logic                 applied_reg;
    logic                 applied_next;
    logic [TIME_BITS-1:0] disagree_reg;
    logic [TIME_BITS-1:0] disagree_next;

    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] sum_sat;
    logic                 do_switch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_mode_reg <= MODE_AUTO;
            adc_threshold_reg <= ADC_BITS'(ADC_THRESHOLD_RST);
            luma_dark_limit_reg <= LUMA_DARK_LIMIT_RST;
            hold_ms_reg <= HOLD_MS_RST;
            settle_ms_reg <= SETTLE_MS_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_IR_MODE:         ir_mode_reg <= wr_data[1:0];
                REG_ADC_THRESHOLD:   adc_threshold_reg <= wr_data[ADC_BITS-1:0];
                REG_LUMA_DARK_LIMIT: luma_dark_limit_reg <= wr_data[LUMA_W-1:0];
                REG_HOLD_MS:         hold_ms_reg <= wr_data[HOLD_W-1:0];
                REG_SETTLE_MS:       settle_ms_reg <= wr_data[SETTLE_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        wanted_next = wanted_reg;
        unique case (ir_mode_reg)
            MODE_AUTO:
            begin
                if (avg_luma <= luma_dark_limit_reg && adc_sample < adc_threshold_reg)
                begin
                    wanted_next = STATE_NIGHT;
                end
                else if (adc_sample >= adc_threshold_reg)
                begin
                    wanted_next = STATE_DAY;
                end
            end
            MODE_NIGHT: wanted_next = STATE_NIGHT;
            MODE_DAY:   wanted_next = STATE_DAY;
            default:    wanted_next = wanted_reg;
        endcase
    end

    assign sum = {1'b0, disagree_reg} + (TIME_BITS + 1)'(elapsed_ms);
    assign sum_sat = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    assign do_switch = (wanted_next != applied_reg) &&
                       (CMP_W'(sum_sat) > CMP_W'(hold_ms_reg));

    always_comb
    begin
        applied_next = do_switch ? wanted_next : applied_reg;
        if (wanted_next == applied_reg || do_switch)
        begin
            disagree_next = '0;
        end
        else
        begin
            disagree_next = sum_sat;
        end
    end

    always_comb
    begin
        two_results = do_switch;
        if (!do_switch)
        begin
            res0 = make_result(ACT_STATUS, applied_reg, '0, 1'b1);
            res1 = make_result(ACT_STATUS, applied_reg, '0, 1'b1);
        end
        else if (wanted_next == STATE_DAY)
        begin
            res0 = make_result(ACT_PINS, STATE_DAY, settle_ms_reg, 1'b0);
            res1 = make_result(ACT_ISP, STATE_DAY, '0, 1'b1);
        end
        else
        begin
            res0 = make_result(ACT_ISP, STATE_NIGHT, settle_ms_reg, 1'b0);
            res1 = make_result(ACT_PINS, STATE_NIGHT, '0, 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg <= STATE_DAY;
            applied_reg <= STATE_DAY;
            disagree_reg <= '0;
        end
        else if (step)
        begin
            wanted_reg <= wanted_next;
            applied_reg <= applied_next;
            disagree_reg <= disagree_next;
        end
    end

endmodule
